// ===== sv/base64_stream_encoder_top_macros.svh =====
// assertion macros for the base64 stream encoder
// expects clk and rst in the scope where a macro is used
`ifndef BASE64_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64_STREAM_ENCODER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define B64E_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64e check failed");

// consequent must hold in the cycle after the antecedent
`define B64E_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64e check failed");

`endif

// ===== sv/b64e_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 encoder
// no dependencies
`default_nettype none

package b64e_pkg;

  localparam int QUEUE_DEPTH = 2;  // power of two
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [5:0] SEXTET_MSK = 6'h3F;

  localparam logic [1:0] NPAD_NONE = 2'd0;
  localparam logic [1:0] NPAD_ONE  = 2'd1;
  localparam logic [1:0] NPAD_TWO  = 2'd2;

  localparam logic [1:0] CHAR_IDX_LAST = 2'd3;

  // one group of up to three bytes ready to be turned into four characters
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  npad;
    logic        last;
  } group_t;

  // state of the character serializer, seen by the top level checks
  typedef struct packed {
    logic       active;
    logic [1:0] idx;
  } back_status_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      return v8 + 8'h41;
    end else if (v8 < 8'd52) begin
      return v8 - 8'd26 + 8'h61;
    end else if (v8 < 8'd62) begin
      return v8 - 8'd52 + 8'h30;
    end else if (v8 == 8'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/b64e_ifs.sv =====
// valid/ready channel interfaces for raw bytes and encoded characters
// depends on nothing
`default_nettype none

interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source(output valid, data_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source(output valid, out_char, last_char, input ready);
  modport sink(input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

// ===== sv/b64e_front.sv =====
// byte gatherer: collects input bytes into groups of three and pushes groups
// depends on b64e_pkg and b64e_byte_if
`default_nettype none

module b64e_front (
  input  wire logic           clk,
  input  wire logic           rst,
  b64e_byte_if.sink           byte_ch,
  output logic                push_valid,
  input  wire logic           push_ready,
  output b64e_pkg::group_t    push_data
);

  logic [15:0] pending_bytes;
  logic [1:0]  pending_count;
  logic        emit;
  logic        accept;

  // a byte that completes a group, or ends the message, produces a group
  assign emit       = byte_ch.end_of_message || pending_count[1];
  assign byte_ch.ready = push_ready;
  assign push_valid = byte_ch.valid && emit;
  assign accept     = byte_ch.valid && byte_ch.ready;

  always_comb begin
    push_data.last = byte_ch.end_of_message;
    if (pending_count[1]) begin
      push_data.group = {pending_bytes, byte_ch.data_byte};
      push_data.npad  = b64e_pkg::NPAD_NONE;
    end else if (pending_count[0]) begin
      push_data.group = {pending_bytes[15:8], byte_ch.data_byte, 8'h00};
      push_data.npad  = b64e_pkg::NPAD_ONE;
    end else begin
      push_data.group = {byte_ch.data_byte, 16'h0000};
      push_data.npad  = b64e_pkg::NPAD_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      pending_count <= '0;
    end else if (accept) begin
      if (emit) begin
        pending_bytes <= '0;
        pending_count <= '0;
      end else if (!pending_count[0]) begin
        pending_bytes <= {byte_ch.data_byte, 8'h00};
        pending_count <= 2'd1;
      end else begin
        pending_bytes <= {pending_bytes[15:8], byte_ch.data_byte};
        pending_count <= 2'd2;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/b64e_fifo.sv =====
// short group queue between the byte gatherer and the character serializer
// depends on b64e_pkg
`default_nettype none

module b64e_fifo (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push_valid,
  output logic                                    push_ready,
  input  wire b64e_pkg::group_t                   push_data,
  output logic                                    pop_valid,
  input  wire logic                               pop_ready,
  output b64e_pkg::group_t                        pop_data,
  output logic [b64e_pkg::QUEUE_LVL_W-1:0]        level
);

  b64e_pkg::group_t                    entries [b64e_pkg::QUEUE_DEPTH];
  logic [b64e_pkg::QUEUE_PTR_W-1:0]    wr_ptr;
  logic [b64e_pkg::QUEUE_PTR_W-1:0]    rd_ptr;
  logic                                push_fire;
  logic                                pop_fire;

  assign push_ready = level != b64e_pkg::QUEUE_LVL_W'(b64e_pkg::QUEUE_DEPTH);
  assign pop_valid  = level != '0;
  assign pop_data   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        level <= level + 1'b1;
      end else if (pop_fire && !push_fire) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/b64e_back.sv =====
// character serializer: turns each queued group into four characters
// depends on b64e_pkg and b64e_char_if
`default_nettype none

module b64e_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pop_valid,
  output logic                     pop_ready,
  input  wire b64e_pkg::group_t    pop_data,
  b64e_char_if.source              char_ch,
  output b64e_pkg::back_status_t   status
);

  b64e_pkg::group_t work;
  logic             active;
  logic [1:0]       idx;
  logic             out_free;
  logic             step;
  logic [4:0]       shift;
  logic [5:0]       sextet;
  logic [2:0]       pad_sum;
  logic [7:0]       char_next;
  logic             last_next;

  assign out_free  = !char_ch.valid || char_ch.ready;
  assign step      = active && out_free;
  assign pop_ready = !active || (out_free && idx == b64e_pkg::CHAR_IDX_LAST);

  // first character takes the top sextet
  assign shift   = 5'd18 - 5'(idx) * 5'd6;
  assign sextet  = 6'(work.group >> shift) & b64e_pkg::SEXTET_MSK;
  assign pad_sum = {1'b0, idx} + {1'b0, work.npad};
  assign char_next = (pad_sum > 3'd3) ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(sextet);
  assign last_next = work.last && idx == b64e_pkg::CHAR_IDX_LAST;

  assign status.active = active;
  assign status.idx    = idx;

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      work <= pop_data;
    end
    if (out_free) begin
      char_ch.out_char  <= char_next;
      char_ch.last_char <= last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      idx           <= '0;
      char_ch.valid <= 1'b0;
    end else begin
      if (out_free) begin
        char_ch.valid <= active;
      end
      if (pop_valid && pop_ready) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (step) begin
        idx <= idx + 1'b1;
        if (idx == b64e_pkg::CHAR_IDX_LAST) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/base64_stream_encoder_top.sv =====
// Streaming base64 encoder (standard alphabet, '=' padding). Raw bytes come in
// on byte_ch, one per accepted item, with end_of_message on the final byte of a
// message; encoded characters leave on char_ch, one per item, last_char set on
// the final character. Every group of three bytes, and every final byte, gives
// four characters. The character port moves one character per cycle while
// char_ch.ready holds, so the serializer sets the sustained rate. The input
// takes one byte per cycle while the two-group queue has room, and the first
// character of a group passes through a queue entry, the serializer's work
// register and the output character register after its last byte is taken.
// Depends on b64e_pkg, the channel interfaces and the three submodules.
`default_nettype none

`include "base64_stream_encoder_top_macros.svh"

module base64_stream_encoder_top (
  input  wire logic   clk,
  input  wire logic   rst,
  b64e_byte_if.sink   byte_ch,
  b64e_char_if.source char_ch
);

  logic                                push_valid;
  logic                                push_ready;
  b64e_pkg::group_t                    push_data;
  logic                                pop_valid;
  logic                                pop_ready;
  b64e_pkg::group_t                    pop_data;
  logic [b64e_pkg::QUEUE_LVL_W-1:0]    q_level;
  b64e_pkg::back_status_t              back_status;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  b64e_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .level      (q_level)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .char_ch   (char_ch),
    .status    (back_status)
  );

  // an end-of-message byte always hands a group to the queue
  `B64E_ASSERT_SAME(eom_pushes_group, byte_ch.valid && byte_ch.ready && byte_ch.end_of_message, push_valid && push_ready)

  // queue level tracks pushes and pops
  `B64E_ASSERT_NEXT(queue_level_tracks, 1'b1, q_level == $past(q_level) + $past(push_valid && push_ready) - $past(pop_valid && pop_ready))

  // a final character is never followed directly by another final character
  `B64E_ASSERT_NEXT(no_back_to_back_last, char_ch.valid && char_ch.ready && char_ch.last_char, !(char_ch.valid && char_ch.last_char))

  // a new group is only taken when the serializer is idle or on its last character
  `B64E_ASSERT_SAME(pop_only_at_group_end, pop_valid && pop_ready && back_status.active, back_status.idx == b64e_pkg::CHAR_IDX_LAST)

endmodule

`default_nettype wire
